// ----- sv/bgsb_pkg.sv -----
// Shared constants, codes and types of the bit-granular stream buffer.
`default_nettype none

package bgsb_pkg;

  // Store geometry
  localparam int unsigned CAPACITY_BITS = 4096;
  localparam int unsigned MAX_WIDTH     = 32;

  // Field widths
  localparam int unsigned OP_W  = 2;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned WID_W = 6;
  localparam int unsigned POS_W = 13;

  // Two banks of words: even words in one, odd words in the other
  localparam int unsigned WORD_W     = VAL_W;
  localparam int unsigned OFF_W      = $clog2(WORD_W);
  localparam int unsigned WIDX_W     = POS_W - OFF_W;
  localparam int unsigned BANK_DEPTH = CAPACITY_BITS / (2 * WORD_W);
  localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);

  // Small queues between the parts
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_READ  = 2'd1;
  localparam op_t OP_SEEK  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ROOM  = 2'd1,
    ST_SHORT    = 2'd2,
    ST_PAST_END = 2'd3
  } status_e;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_e;

  typedef struct packed {
    op_t              op;
    logic [VAL_W-1:0] value;
    logic [WID_W-1:0] width;
    logic [POS_W-1:0] new_position;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    status_e          status;
    logic [POS_W-1:0] cursor;
    logic [POS_W-1:0] length;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/bgsb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bgsb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- sv/bgsb_front.sv -----
// Front end: accepts items, saturates the width and queues decoded commands.
`default_nettype none

module bgsb_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [bgsb_pkg::OP_W-1:0]     operation_i,
  input  wire logic [bgsb_pkg::VAL_W-1:0]    value_i,
  input  wire logic [bgsb_pkg::WID_W-1:0]    width_i,
  input  wire logic [bgsb_pkg::POS_W-1:0]    new_position_i,
  output logic                               cmd_valid_o,
  output bgsb_pkg::cmd_t                     cmd_o,
  input  wire logic                          cmd_pop_i
);

  bgsb_pkg::cmd_t                    mem_q [bgsb_pkg::QDEPTH];
  logic [bgsb_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [bgsb_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [bgsb_pkg::QCNT_W-1:0]       count_q, count_d;
  logic                              do_push, do_pop;
  bgsb_pkg::cmd_t                    cmd_in;

  always_comb begin
    cmd_in.op           = operation_i;
    cmd_in.value        = value_i;
    cmd_in.new_position = new_position_i;
    // clamp oversized widths
    if (width_i > bgsb_pkg::WID_W'(bgsb_pkg::MAX_WIDTH)) begin
      cmd_in.width = bgsb_pkg::WID_W'(bgsb_pkg::MAX_WIDTH);
    end else begin
      cmd_in.width = width_i;
    end
  end

  assign full        = (count_q == bgsb_pkg::QCNT_W'(bgsb_pkg::QDEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ----- sv/bgsb_back.sv -----
// Back end: checks each command, does the read-modify-write of the store and emits a result.
`default_nettype none

module bgsb_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire bgsb_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                res_push_o,
  output bgsb_pkg::res_t      res_o,
  input  wire logic           res_full_i
);

  localparam int unsigned PAIR_W = 2 * bgsb_pkg::WORD_W;
  localparam int unsigned KW     = bgsb_pkg::WIDX_W - 1;

  function automatic logic [bgsb_pkg::WORD_W-1:0] bit_rev(
    input logic [bgsb_pkg::WORD_W-1:0] x
  );
    logic [bgsb_pkg::WORD_W-1:0] r;
    for (int i = 0; i < bgsb_pkg::WORD_W; i++) begin
      r[i] = x[bgsb_pkg::WORD_W-1-i];
    end
    return r;
  endfunction

  bgsb_pkg::back_state_e state_q, state_d;

  logic [bgsb_pkg::POS_W-1:0]   cursor_q, cursor_d;
  logic [bgsb_pkg::POS_W-1:0]   length_q, length_d;

  // issue-stage values
  logic [bgsb_pkg::POS_W:0]     end_pos;
  bgsb_pkg::status_e            status_d;
  logic                         wr_ok_d, rd_ok_d;
  logic [bgsb_pkg::WORD_W:0]    low_mask_wide;
  logic [bgsb_pkg::WORD_W-1:0]  low_mask;
  logic [bgsb_pkg::WORD_W-1:0]  vbits_rev;
  logic [bgsb_pkg::WID_W-1:0]   pad;
  logic [bgsb_pkg::OFF_W-1:0]   off_d;
  logic [bgsb_pkg::WIDX_W-1:0]  widx;
  logic [KW-1:0]                kidx, kidx_p1;
  logic [bgsb_pkg::BANK_AW-1:0] addr_even_d, addr_odd_d;

  // execute-stage registers
  bgsb_pkg::status_e            status_q;
  logic                         wr_ok_q, rd_ok_q, swap_q;
  logic [bgsb_pkg::WID_W-1:0]   width_q;
  logic [bgsb_pkg::OFF_W-1:0]   off_q;
  logic [PAIR_W-1:0]            data_q, mask_q;
  logic [bgsb_pkg::BANK_AW-1:0] addr_even_q, addr_odd_q;

  // execute-stage values
  logic [bgsb_pkg::WORD_W-1:0]  rd_even, rd_odd, lo_word, hi_word;
  logic [PAIR_W-1:0]            pair, merged, pair_shr;
  logic [bgsb_pkg::WORD_W-1:0]  read_bits;
  logic                         wr_lo, wr_hi, we_even, we_odd;
  logic [bgsb_pkg::WORD_W-1:0]  wdata_even, wdata_odd;

  logic issue;

  // ---- state machine ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      bgsb_pkg::BK_IDLE: if (cmd_valid_i && !res_full_i) state_d = bgsb_pkg::BK_EXEC;
      bgsb_pkg::BK_EXEC: state_d = bgsb_pkg::BK_IDLE;
      default:           state_d = bgsb_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      bgsb_pkg::BK_IDLE: cmd_pop_o  = cmd_valid_i && !res_full_i;
      bgsb_pkg::BK_EXEC: res_push_o = 1'b1;
      default: ;
    endcase
  end

  assign issue = cmd_pop_o;

  // ---- issue: classify and prepare the masked field ----
  always_comb begin
    end_pos  = {1'b0, cursor_q} + (bgsb_pkg::POS_W + 1)'(cmd_i.width);
    status_d = bgsb_pkg::ST_OK;
    wr_ok_d  = 1'b0;
    rd_ok_d  = 1'b0;
    cursor_d = cursor_q;
    length_d = length_q;
    case (cmd_i.op)
      bgsb_pkg::OP_WRITE: begin
        if (end_pos > (bgsb_pkg::POS_W + 1)'(bgsb_pkg::CAPACITY_BITS)) begin
          status_d = bgsb_pkg::ST_NO_ROOM;
        end else begin
          wr_ok_d  = 1'b1;
          cursor_d = end_pos[bgsb_pkg::POS_W-1:0];
          length_d = end_pos[bgsb_pkg::POS_W-1:0];
        end
      end
      bgsb_pkg::OP_READ: begin
        if (end_pos > {1'b0, length_q}) begin
          status_d = bgsb_pkg::ST_SHORT;
        end else begin
          rd_ok_d  = 1'b1;
          cursor_d = end_pos[bgsb_pkg::POS_W-1:0];
        end
      end
      bgsb_pkg::OP_SEEK: begin
        if (cmd_i.new_position > length_q) begin
          status_d = bgsb_pkg::ST_PAST_END;
        end else begin
          cursor_d = cmd_i.new_position;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    low_mask_wide = ((bgsb_pkg::WORD_W + 1)'(1) << cmd_i.width) - 1'b1;
    low_mask      = low_mask_wide[bgsb_pkg::WORD_W-1:0];
    pad           = bgsb_pkg::WID_W'(bgsb_pkg::WORD_W) - cmd_i.width;
    // first bit of the field lands at the cursor
    vbits_rev     = bit_rev(cmd_i.value & low_mask) >> pad;
    off_d         = cursor_q[bgsb_pkg::OFF_W-1:0];
    widx          = cursor_q[bgsb_pkg::POS_W-1:bgsb_pkg::OFF_W];
    kidx          = widx[bgsb_pkg::WIDX_W-1:1];
    kidx_p1       = kidx + 1'b1;
    addr_odd_d    = kidx[bgsb_pkg::BANK_AW-1:0];
    addr_even_d   = widx[0] ? kidx_p1[bgsb_pkg::BANK_AW-1:0] : kidx[bgsb_pkg::BANK_AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bgsb_pkg::BK_IDLE;
      cursor_q <= '0;
      length_q <= '0;
    end else begin
      state_q <= state_d;
      if (issue) begin
        cursor_q <= cursor_d;
        length_q <= length_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ok_q <= 1'b0;
    end else if (issue) begin
      wr_ok_q <= wr_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      status_q    <= status_d;
      rd_ok_q     <= rd_ok_d;
      swap_q      <= widx[0];
      width_q     <= cmd_i.width;
      off_q       <= off_d;
      data_q      <= {{bgsb_pkg::WORD_W{1'b0}}, vbits_rev} << off_d;
      mask_q      <= {{bgsb_pkg::WORD_W{1'b0}}, low_mask} << off_d;
      addr_even_q <= addr_even_d;
      addr_odd_q  <= addr_odd_d;
    end
  end

  // ---- execute: read-modify-write of the word pair ----
  always_comb begin
    lo_word   = swap_q ? rd_odd : rd_even;
    hi_word   = swap_q ? rd_even : rd_odd;
    pair      = {hi_word, lo_word};
    merged    = (pair & ~mask_q) | data_q;
    pair_shr  = pair >> off_q;
    read_bits = bit_rev(pair_shr[bgsb_pkg::WORD_W-1:0])
                >> (bgsb_pkg::WID_W'(bgsb_pkg::WORD_W) - width_q);

    wr_lo = (state_q == bgsb_pkg::BK_EXEC) && wr_ok_q && (|mask_q[bgsb_pkg::WORD_W-1:0]);
    wr_hi = (state_q == bgsb_pkg::BK_EXEC) && wr_ok_q && (|mask_q[PAIR_W-1:bgsb_pkg::WORD_W]);
    we_even    = swap_q ? wr_hi : wr_lo;
    we_odd     = swap_q ? wr_lo : wr_hi;
    wdata_even = swap_q ? merged[PAIR_W-1:bgsb_pkg::WORD_W] : merged[bgsb_pkg::WORD_W-1:0];
    wdata_odd  = swap_q ? merged[bgsb_pkg::WORD_W-1:0] : merged[PAIR_W-1:bgsb_pkg::WORD_W];

    res_o.read_value = rd_ok_q ? read_bits : '0;
    res_o.status     = status_q;
    res_o.cursor     = cursor_q;
    res_o.length     = length_q;
  end

  bgsb_ram #(
    .WIDTH(bgsb_pkg::WORD_W),
    .DEPTH(bgsb_pkg::BANK_DEPTH)
  ) u_bank_even (
    .clk_i  (clk_i),
    .we_i   (we_even),
    .waddr_i(addr_even_q),
    .wdata_i(wdata_even),
    .raddr_i(addr_even_d),
    .rdata_o(rd_even)
  );

  bgsb_ram #(
    .WIDTH(bgsb_pkg::WORD_W),
    .DEPTH(bgsb_pkg::BANK_DEPTH)
  ) u_bank_odd (
    .clk_i  (clk_i),
    .we_i   (we_odd),
    .waddr_i(addr_odd_q),
    .wdata_i(wdata_odd),
    .raddr_i(addr_odd_d),
    .rdata_o(rd_odd)
  );

endmodule

`default_nettype wire

// ----- sv/bgsb_out_queue.sv -----
// Result queue: holds finished results until the receiver pops them.
`default_nettype none

module bgsb_out_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           res_push_i,
  input  wire bgsb_pkg::res_t res_i,
  output logic                res_full_o,
  output logic                empty,
  input  wire logic           pop,
  output bgsb_pkg::res_t      head_o
);

  bgsb_pkg::res_t              mem_q [bgsb_pkg::QDEPTH];
  logic [bgsb_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [bgsb_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [bgsb_pkg::QCNT_W-1:0] count_q, count_d;
  logic                        do_push, do_pop;

  assign res_full_o = (count_q == bgsb_pkg::QCNT_W'(bgsb_pkg::QDEPTH));
  assign empty      = (count_q == '0);
  assign head_o     = mem_q[rd_ptr_q];
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop && !empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/bit_granular_stream_buffer.sv -----
// Bit-granular stream buffer: write, read and seek on a 4096-bit store.
//
// Input channel: drive operation_i, value_i, width_i, new_position_i and
// raise push; the item is taken at a clock edge where push is high and full
// is low. Two items fit in the command queue ahead of the executor.
// Result channel: while empty is low the oldest result sits on read_value_o,
// status_o, cursor_o and length_o; raise pop to take it.
// Each item gives exactly one result, in order. An item passes from the
// command queue through the issue and execute states into the result queue.
// The executor takes one item at a time and no new one until it is done:
// it reads the word pair under the cursor from two 32-bit banks as it takes
// the item and writes it back merged in its execute state.
// Reset clears the cursor, the length and both queues; the store contents
// are undefined until written, and no clearing pass runs.
// When the receiver stalls, the result queue fills, the executor holds, and
// full rises once the command queue is also full.
`default_nettype none

module bit_granular_stream_buffer (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [bgsb_pkg::OP_W-1:0]  operation_i,
  input  wire logic [bgsb_pkg::VAL_W-1:0] value_i,
  input  wire logic [bgsb_pkg::WID_W-1:0] width_i,
  input  wire logic [bgsb_pkg::POS_W-1:0] new_position_i,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [bgsb_pkg::VAL_W-1:0]      read_value_o,
  output logic [1:0]                      status_o,
  output logic [bgsb_pkg::POS_W-1:0]      cursor_o,
  output logic [bgsb_pkg::POS_W-1:0]      length_o
);

  logic           cmd_valid, cmd_pop, res_push, res_full;
  bgsb_pkg::cmd_t cmd;
  bgsb_pkg::res_t res, head;

  bgsb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .operation_i   (operation_i),
    .value_i       (value_i),
    .width_i       (width_i),
    .new_position_i(new_position_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  bgsb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_push_o (res_push),
    .res_o      (res),
    .res_full_i (res_full)
  );

  bgsb_out_queue u_out_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_push_i(res_push),
    .res_i     (res),
    .res_full_o(res_full),
    .empty     (empty),
    .pop       (pop),
    .head_o    (head)
  );

  assign read_value_o = head.read_value;
  assign status_o     = head.status;
  assign cursor_o     = head.cursor;
  assign length_o     = head.length;

endmodule

`default_nettype wire
